// ===== design/cell_extract_point_renumber_core_defines.svh =====
// ----------------------------------------------------------------------------
// cell extract point renumber - assertion macros
// Shared concurrent check macros, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CELL_EXTRACT_POINT_RENUMBER_CORE_DEFINES_SVH
`define CELL_EXTRACT_POINT_RENUMBER_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define CEPR_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cepr: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define CEPR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cepr: next-cycle check failed");

`endif

// ===== design/cepr_pkg.sv =====
// ----------------------------------------------------------------------------
// cepr_pkg
// Types, constants and codes shared by the cell extract / point renumber block.
// ----------------------------------------------------------------------------
package cepr_pkg;

  localparam int DEFAULT_POINT_CAPACITY  = 65536;
  localparam int DEFAULT_MAX_CELL_POINTS = 16;

  // point ids are 16 bits, so at most this many map entries are ever needed
  localparam int POINT_ID_W    = 16;
  localparam int POINT_ID_SPAN = 65536;
  localparam int NIDX_W        = 17;

  localparam int EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX   = 8'hFF;

  localparam logic [POINT_ID_W-1:0] UNUSED_MARK = 16'hFFFF;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_CLIP_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_ID_RANGE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_ID_RANGE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_X_RANGE        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_RANGE        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Z_RANGE        = 3'd5;

  localparam logic [2:0]  CLIP_MODE_RST      = 3'd0;
  localparam logic [63:0] CELL_ID_RANGE_RST  = 64'hFFFF_FFFF_0000_0000;
  localparam logic [31:0] POINT_ID_RANGE_RST = 32'hFFFF_0000;
  localparam logic [63:0] AXIS_RANGE_RST     = 64'h7FFF_FFFF_8000_0000;

  localparam int CLIP_CELL  = 0;
  localparam int CLIP_POINT = 1;
  localparam int CLIP_BOX   = 2;

  typedef struct packed {
    logic                  new_set;
    logic [31:0]           cell_id;
    logic [7:0]            cell_type;
    logic [POINT_ID_W-1:0] point_id;
    logic signed [31:0]    x_coord;
    logic signed [31:0]    y_coord;
    logic signed [31:0]    z_coord;
    logic                  last_vertex;
  } vertex_t;

  typedef struct packed {
    logic [31:0]           out_cell_index;
    logic [7:0]            out_cell_type;
    logic [3:0]            vertex_slot;
    logic [POINT_ID_W-1:0] source_point;
    logic [POINT_ID_W-1:0] renumbered_point;
    logic                  first_use;
    logic                  last_of_cell;
  } result_t;

  typedef struct packed {
    logic [EPOCH_W-1:0]    epoch;
    logic [POINT_ID_W-1:0] idx;
  } map_entry_t;

  typedef struct packed {
    logic                  clearing;
    logic                  hit;
    logic [POINT_ID_W-1:0] idx;
  } map_rd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_EMIT_BUF,
    ST_EMIT_MAP,
    ST_EMIT_OUT
  } state_t;

endpackage

// ===== design/cepr_chan_if.sv =====
// ----------------------------------------------------------------------------
// cepr_chan_if
// Valid/ready channel carrying one word of a chosen type.
// ----------------------------------------------------------------------------
interface cepr_chan_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/cepr_point_map.sv =====
// ----------------------------------------------------------------------------
// cepr_point_map
// Point renumber table: one entry per source point holding an epoch tag and
// the compacted index. An entry is live only when its tag equals the current
// epoch; a sweep zeroes every tag after reset and on epoch wrap.
// ----------------------------------------------------------------------------
module cepr_point_map #(
  parameter int MAP_DEPTH = cepr_pkg::POINT_ID_SPAN,
  localparam int AW = $clog2(MAP_DEPTH)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                clear_req,
  input  logic [cepr_pkg::EPOCH_W-1:0]        epoch,
  input  logic                                rd_en,
  input  logic [AW-1:0]                       rd_addr,
  input  logic                                wr_en,
  input  logic [AW-1:0]                       wr_addr,
  input  logic [cepr_pkg::POINT_ID_W-1:0]     wr_idx,
  output cepr_pkg::map_rd_t                   status
);

  cepr_pkg::map_entry_t map_mem [MAP_DEPTH];
  cepr_pkg::map_entry_t rd_q;
  logic                 clearing;
  logic [AW-1:0]        clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(MAP_DEPTH - 1)) begin
        clearing <= 1'b0;
        clr_addr <= '0;
      end else begin
        clr_addr <= clr_addr + AW'(1);
      end
    end else if (clear_req) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end
  end

  // epoch zero is never current, so a swept entry reads as empty
  always_ff @(posedge clk) begin
    if (clearing) begin
      map_mem[clr_addr] <= '0;
    end else if (wr_en) begin
      map_mem[wr_addr] <= '{epoch: epoch, idx: wr_idx};
    end
    if (rd_en) begin
      rd_q <= map_mem[rd_addr];
    end
  end

  assign status.clearing = clearing;
  assign status.hit      = (rd_q.epoch == epoch);
  assign status.idx      = rd_q.idx;

endmodule

// ===== design/cell_extract_point_renumber_core.sv =====
// ----------------------------------------------------------------------------
// cell_extract_point_renumber_core
// Cell visibility filter with compacted point renumbering.
//
// vertex channel: one cell vertex per word; last_vertex closes the cell.
// result channel: one word per buffered vertex of each visible cell.
// cfg port: cfg_we/cfg_index/cfg_data; the user must write it only while the
// block is idle, which the block does not enforce. Closing vertex of a visible
// cell with n buffered vertices: the n words are emitted before the next vertex
// is taken; each emitted vertex costs a vertex buffer read followed by a map
// table read. Closing vertex of a hidden cell: no words out. Reset runs a
// sweep over the point map (one entry a cycle, over all map entries, 65536 by
// default) with vertex ready low. The same sweep runs on the new_set word
// that wraps the 8-bit map epoch (every 255th).
// The result word sits in an output register; a stalled receiver holds the
// emission sequence at that vertex until the word is taken.
// ----------------------------------------------------------------------------
`include "cell_extract_point_renumber_core_defines.svh"

module cell_extract_point_renumber_core #(
  parameter int POINT_CAPACITY  = cepr_pkg::DEFAULT_POINT_CAPACITY,
  parameter int MAX_CELL_POINTS = cepr_pkg::DEFAULT_MAX_CELL_POINTS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [cepr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cepr_pkg::CFG_DATA_W-1:0]   cfg_data,
  cepr_chan_if.sink                         vertex,
  cepr_chan_if.source                       result
);

  localparam int MAP_DEPTH = (POINT_CAPACITY < cepr_pkg::POINT_ID_SPAN) ?
                             POINT_CAPACITY : cepr_pkg::POINT_ID_SPAN;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int VC_W      = $clog2(MAX_CELL_POINTS + 1);
  localparam int VB_AW     = (MAX_CELL_POINTS > 1) ? $clog2(MAX_CELL_POINTS) : 1;

  // configuration registers
  logic [2:0]  clip_mode;
  logic [63:0] cell_id_range;
  logic [31:0] point_id_range;
  logic [63:0] x_range;
  logic [63:0] y_range;
  logic [63:0] z_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_mode      <= cepr_pkg::CLIP_MODE_RST;
      cell_id_range  <= cepr_pkg::CELL_ID_RANGE_RST;
      point_id_range <= cepr_pkg::POINT_ID_RANGE_RST;
      x_range        <= cepr_pkg::AXIS_RANGE_RST;
      y_range        <= cepr_pkg::AXIS_RANGE_RST;
      z_range        <= cepr_pkg::AXIS_RANGE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cepr_pkg::REG_CLIP_MODE:      clip_mode      <= cfg_data[2:0];
        cepr_pkg::REG_CELL_ID_RANGE:  cell_id_range  <= cfg_data;
        cepr_pkg::REG_POINT_ID_RANGE: point_id_range <= cfg_data[31:0];
        cepr_pkg::REG_X_RANGE:        x_range        <= cfg_data;
        cepr_pkg::REG_Y_RANGE:        y_range        <= cfg_data;
        cepr_pkg::REG_Z_RANGE:        z_range        <= cfg_data;
        default: ;
      endcase
    end
  end

  // a max below its min acts as the min: c > max(lo, hi)
  function automatic logic axis_out(input logic [63:0] rng,
                                    input logic signed [31:0] c);
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    lo = rng[31:0];
    hi = rng[63:32];
    return (c < lo) || ((c > hi) && (c > lo));
  endfunction

  // control state
  cepr_pkg::state_t              state, state_next;
  logic [VC_W-1:0]               vcount, vcount_next;
  logic                          visible, visible_next;
  logic [VC_W-1:0]               k, k_next;
  logic [31:0]                   emitted_cells, emitted_next;
  logic [cepr_pkg::NIDX_W-1:0]   next_idx, next_idx_next;
  logic [cepr_pkg::EPOCH_W-1:0]  epoch, epoch_next;
  logic                          pend_emit, pend_next;
  logic [7:0]                    ctype_q, ctype_next;

  // vertex buffer
  logic [cepr_pkg::POINT_ID_W-1:0] vbuf_mem [MAX_CELL_POINTS];
  logic [cepr_pkg::POINT_ID_W-1:0] vbuf_q;
  logic                            vb_we;
  logic [VB_AW-1:0]                vb_waddr;

  // point map
  cepr_pkg::map_rd_t map_st;
  logic              clear_req;
  logic              map_rd_en;
  logic              map_we;

  // result register
  logic              res_valid;
  cepr_pkg::result_t res_data;
  cepr_pkg::result_t out_word;
  logic              out_load;
  logic              out_free;
  logic              vertex_ready;

  // per-vertex tests on the incoming word
  cepr_pkg::vertex_t vin;
  logic              vis_base;
  logic [VC_W-1:0]   vc_base;
  logic              vc_room;
  logic [VC_W-1:0]   vc_after;
  logic              point_fail;
  logic              box_fail;
  logic              cell_fail;
  logic              vis_new;

  assign vin      = vertex.data;
  assign vis_base = vin.new_set ? 1'b1 : visible;
  assign vc_base  = vin.new_set ? '0 : vcount;
  assign vc_room  = (vc_base < VC_W'(MAX_CELL_POINTS));
  assign vc_after = vc_room ? vc_base + VC_W'(1) : vc_base;
  assign vb_waddr = vc_base[VB_AW-1:0];

  assign point_fail = clip_mode[cepr_pkg::CLIP_POINT] &&
                      ((vin.point_id < point_id_range[15:0]) ||
                       (vin.point_id > point_id_range[31:16]));
  assign box_fail   = clip_mode[cepr_pkg::CLIP_BOX] &&
                      (axis_out(x_range, vin.x_coord) ||
                       axis_out(y_range, vin.y_coord) ||
                       axis_out(z_range, vin.z_coord));
  assign cell_fail  = vin.last_vertex && clip_mode[cepr_pkg::CLIP_CELL] &&
                      ((vin.cell_id < cell_id_range[31:0]) ||
                       (vin.cell_id > cell_id_range[63:32]));
  assign vis_new    = vis_base && !point_fail && !box_fail && !cell_fail;

  // map lookup resolution for the vertex being emitted
  logic                            in_cap;
  logic                            map_hit;
  logic                            can_alloc;
  logic                            k_last;
  logic [cepr_pkg::POINT_ID_W-1:0] renum;

  assign in_cap    = (32'(vbuf_q) < 32'(POINT_CAPACITY));
  assign map_hit   = in_cap && map_st.hit;
  assign can_alloc = in_cap && !map_st.hit && (32'(next_idx) < 32'(POINT_CAPACITY));
  assign k_last    = (k == vcount - VC_W'(1));
  assign renum     = map_hit   ? map_st.idx :
                     can_alloc ? next_idx[cepr_pkg::POINT_ID_W-1:0] :
                                 cepr_pkg::UNUSED_MARK;

  assign out_word.out_cell_index   = emitted_cells;
  assign out_word.out_cell_type    = ctype_q;
  assign out_word.vertex_slot      = 4'(k);
  assign out_word.source_point     = vbuf_q;
  assign out_word.renumbered_point = renum;
  assign out_word.first_use        = can_alloc;
  assign out_word.last_of_cell     = k_last;

  assign out_free = !res_valid || result.ready;

  always_comb begin
    state_next    = state;
    vcount_next   = vcount;
    visible_next  = visible;
    k_next        = k;
    emitted_next  = emitted_cells;
    next_idx_next = next_idx;
    epoch_next    = epoch;
    pend_next     = pend_emit;
    ctype_next    = ctype_q;
    vertex_ready  = 1'b0;
    clear_req     = 1'b0;
    vb_we         = 1'b0;
    map_rd_en     = 1'b0;
    map_we        = 1'b0;
    out_load      = 1'b0;
    case (state)
      cepr_pkg::ST_IDLE: begin
        vertex_ready = 1'b1;
        if (vertex.valid) begin
          vb_we = vc_room;
          if (vin.new_set) begin
            next_idx_next = '0;
            emitted_next  = '0;
            // epoch wrap forces a sweep before the next lookup
            clear_req  = (epoch == cepr_pkg::EPOCH_MAX);
            epoch_next = (epoch == cepr_pkg::EPOCH_MAX) ? cepr_pkg::EPOCH_FIRST
                                                        : epoch + 1'b1;
          end
          if (vin.last_vertex) begin
            ctype_next   = vin.cell_type;
            visible_next = 1'b1;
            vcount_next  = vis_new ? vc_after : '0;
            k_next       = '0;
          end else begin
            visible_next = vis_new;
            vcount_next  = vc_after;
          end
          pend_next = vin.last_vertex && vis_new;
          if (clear_req) begin
            state_next = cepr_pkg::ST_CLEAR;
          end else if (vin.last_vertex && vis_new) begin
            state_next = cepr_pkg::ST_EMIT_BUF;
          end
        end
      end
      cepr_pkg::ST_CLEAR: begin
        if (!map_st.clearing) begin
          state_next = pend_emit ? cepr_pkg::ST_EMIT_BUF : cepr_pkg::ST_IDLE;
        end
      end
      cepr_pkg::ST_EMIT_BUF: begin
        state_next = cepr_pkg::ST_EMIT_MAP;
      end
      cepr_pkg::ST_EMIT_MAP: begin
        map_rd_en  = 1'b1;
        state_next = cepr_pkg::ST_EMIT_OUT;
      end
      cepr_pkg::ST_EMIT_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (can_alloc) begin
            map_we        = 1'b1;
            next_idx_next = next_idx + 1'b1;
          end
          if (k_last) begin
            vcount_next  = '0;
            visible_next = 1'b1;
            k_next       = '0;
            emitted_next = emitted_cells + 32'd1;
            pend_next    = 1'b0;
            state_next   = cepr_pkg::ST_IDLE;
          end else begin
            // buffer read for the next vertex issues on this edge
            k_next     = k + VC_W'(1);
            state_next = cepr_pkg::ST_EMIT_MAP;
          end
        end
      end
      default: begin
        state_next = cepr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= cepr_pkg::ST_CLEAR;
      vcount        <= '0;
      visible       <= 1'b1;
      k             <= '0;
      emitted_cells <= '0;
      next_idx      <= '0;
      epoch         <= cepr_pkg::EPOCH_FIRST;
      pend_emit     <= 1'b0;
    end else begin
      state         <= state_next;
      vcount        <= vcount_next;
      visible       <= visible_next;
      k             <= k_next;
      emitted_cells <= emitted_next;
      next_idx      <= next_idx_next;
      epoch         <= epoch_next;
      pend_emit     <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    ctype_q <= ctype_next;
  end

  always_ff @(posedge clk) begin
    if (vb_we) begin
      vbuf_mem[vb_waddr] <= vin.point_id;
    end
    vbuf_q <= vbuf_mem[k_next[VB_AW-1:0]];
  end

  cepr_point_map #(
    .MAP_DEPTH (MAP_DEPTH)
  ) u_map (
    .clk       (clk),
    .rst       (rst),
    .clear_req (clear_req),
    .epoch     (epoch),
    .rd_en     (map_rd_en),
    .rd_addr   (vbuf_q[MAP_AW-1:0]),
    .wr_en     (map_we),
    .wr_addr   (vbuf_q[MAP_AW-1:0]),
    .wr_idx    (next_idx[cepr_pkg::POINT_ID_W-1:0]),
    .status    (map_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_data <= out_word;
    end
  end

  assign vertex.ready = vertex_ready;
  assign result.valid = res_valid;
  assign result.data  = res_data;

  `CEPR_ASSERT_NOW(a_no_accept_while_sweep, vertex.valid && vertex.ready, !map_st.clearing)
  `CEPR_ASSERT_NEXT(a_fresh_bumps_index, out_load && out_word.first_use, next_idx == $past(next_idx) + 1'b1)
  `CEPR_ASSERT_NOW(a_hit_below_alloc, state == cepr_pkg::ST_EMIT_OUT && map_hit, 32'(map_st.idx) < 32'(next_idx))

endmodule
